// ===== rtl/ckcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ckcs_pkg;

	// Field widths of the pixel stream and of the corner results.
	localparam int unsigned LUMA_W    = 8;
	localparam int unsigned CHROMA_W  = 8;
	localparam int unsigned ROW_W     = 9;
	localparam int unsigned COL_W     = 10;
	localparam int unsigned THR_W     = 10;
	localparam int unsigned KEY_W     = 24;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 24;

	localparam int unsigned IN_BITS    = 4 * LUMA_W + ROW_W + COL_W;
	localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS    = 2 * (ROW_W + COL_W);
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_X      = 3'd0,
		CFG_LEFT_Y      = 3'd1,
		CFG_RIGHT_X     = 3'd2,
		CFG_RIGHT_Y     = 3'd3,
		CFG_LEFT_KEY    = 3'd4,
		CFG_RIGHT_KEY   = 3'd5,
		CFG_THRESHOLD   = 3'd6
	} cfg_index_t;

	localparam logic [KEY_W-1:0] KEY_RESET = 24'hFF8080;
	localparam logic [THR_W-1:0] THR_RESET = 10'd15;

	// One macropixel as held in the input stage.
	typedef struct packed {
		logic             frame_end;
		logic [COL_W-1:0] pair_column;
		logic [ROW_W-1:0] pixel_row;
		logic [7:0]       chroma_red;
		logic [7:0]       luma_second;
		logic [7:0]       chroma_blue;
		logic [7:0]       luma_first;
	} pixel_pair_t;

	// Kept corner position of one window.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} corner_t;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	// Colour distance |Y-y| + |U-u| + |V-v|, at most 765.
	function automatic logic [THR_W-1:0] color_dist(input logic [7:0] y, input logic [7:0] u,
			input logic [7:0] v, input logic [KEY_W-1:0] key);
		color_dist = THR_W'(abs_diff(key[23:16], y)) + THR_W'(abs_diff(key[15:8], u))
			+ THR_W'(abs_diff(key[7:0], v));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/color_key_corner_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Colour-key corner search over a YUYV raster stream.
// The slave stream carries one macropixel per request: two luma samples sharing
// one U and one V sample, tagged with the row and the even column of the pair,
// with tlast set on the last pair of a frame. Each of two square windows, set
// by the configuration port, keeps the best matching pixel of the frame: the
// left window the one furthest towards row minus column, the right window the
// one furthest towards row plus column. On the tlast pair the master stream
// emits both kept positions as one request and the search starts afresh.
// A request is taken every cycle unless a tlast pair waits in the input stage
// behind a held result. A pair is registered in the input stage, where it is
// compared and the kept corners are updated; the result of a tlast pair goes
// from there into the output register and is offered until it is taken. The
// rate is set by the single compare-and-update step on the kept corners.
// When the receiver stalls, a held result keeps the next tlast pair waiting in
// the input stage, and with it the slave stream; the pairs ahead of that tlast
// pair keep flowing. Reset empties both stages and loads the register defaults;
// a write to any of the seven registers also restarts the search of both windows.
module color_key_corner_search #(
	parameter int unsigned FRAME_WIDTH  = 640,
	parameter int unsigned FRAME_HEIGHT = 480,
	parameter int unsigned RADIUS       = 25
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// tdata: luma_first, chroma_blue, luma_second, chroma_red, pixel_row,
	// pair_column, zero fill
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [ckcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                                s_axis_tlast,
	// tdata: left_corner_col, left_corner_row, right_corner_col,
	// right_corner_row, zero fill
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [ckcs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	input  wire logic                                cfg_wen,
	input  wire logic [ckcs_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire logic [ckcs_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
	import ckcs_pkg::*;

	localparam logic [10:0] RAD    = 11'(RADIUS);
	localparam logic [10:0] FW_LIM = 11'(FRAME_WIDTH);
	localparam logic [10:0] FH_LIM = 11'(FRAME_HEIGHT);

	// Configuration registers.
	logic [COL_W-1:0] left_x_q, right_x_q;
	logic [ROW_W-1:0] left_y_q, right_y_q;
	logic [KEY_W-1:0] left_key_q, right_key_q;
	logic [THR_W-1:0] thr_q;

	// Input stage, kept corners and output register.
	logic             valid_s1;
	pixel_pair_t      item_s1;
	logic             left_fresh_q, right_fresh_q;
	corner_t          left_best_q, right_best_q;
	logic             out_valid_q;
	corner_t          out_left_q, out_right_q;

	// Window bounds: start rounded down to even, end exclusive.
	logic [10:0] l_sx, l_ex, l_sy, l_ey, r_sx, r_ex, r_sy, r_ey;
	logic [10:0] l_cx, l_cy, r_cx, r_cy;
	corner_t     left_init, right_init, left_cur, right_cur, left_next, right_next;

	logic [COL_W-1:0] col0, col1;
	logic [10:0]      row_w, col0_w, col1_w;
	logic             l_in, r_in;
	logic [THR_W-1:0] l_d0, l_d1, r_d0, r_d1;
	logic             l_m0, l_m1, r_m0, r_m1;
	logic             l_upd, r_upd;
	logic             go_s1, cfg_hit;

	always_comb begin
		l_cx = 11'(left_x_q);
		l_cy = 11'(left_y_q);
		r_cx = 11'(right_x_q);
		r_cy = 11'(right_y_q);
		l_sx = (l_cx > RAD) ? ((l_cx - RAD) & ~11'd1) : 11'd0;
		l_sy = (l_cy > RAD) ? ((l_cy - RAD) & ~11'd1) : 11'd0;
		r_sx = (r_cx > RAD) ? ((r_cx - RAD) & ~11'd1) : 11'd0;
		r_sy = (r_cy > RAD) ? ((r_cy - RAD) & ~11'd1) : 11'd0;
		l_ex = (l_cx + RAD <= FW_LIM) ? (l_cx + RAD) : FW_LIM;
		l_ey = (l_cy + RAD <= FH_LIM) ? (l_cy + RAD) : FH_LIM;
		r_ex = (r_cx + RAD <= FW_LIM) ? (r_cx + RAD) : FW_LIM;
		r_ey = (r_cy + RAD <= FH_LIM) ? (r_cy + RAD) : FH_LIM;

		left_init.col  = COL_W'(l_ex - 11'd1);
		left_init.row  = ROW_W'(l_sy);
		right_init.col = COL_W'(r_sx);
		right_init.row = ROW_W'(r_sy);

		// A fresh window still holds its starting position.
		left_cur  = left_fresh_q  ? left_init  : left_best_q;
		right_cur = right_fresh_q ? right_init : right_best_q;
	end

	always_comb begin
		// Bit 0 of the pair column is ignored.
		col0   = {item_s1.pair_column[COL_W-1:1], 1'b0};
		col1   = {item_s1.pair_column[COL_W-1:1], 1'b1};
		row_w  = 11'(item_s1.pixel_row);
		col0_w = 11'(col0);
		col1_w = 11'(col1);

		l_in = (row_w >= l_sy) && (row_w < l_ey) && (col0_w >= l_sx) && (col0_w < l_ex);
		r_in = (row_w >= r_sy) && (row_w < r_ey) && (col0_w >= r_sx) && (col0_w < r_ex);

		l_d0 = color_dist(item_s1.luma_first,  item_s1.chroma_blue, item_s1.chroma_red, left_key_q);
		l_d1 = color_dist(item_s1.luma_second, item_s1.chroma_blue, item_s1.chroma_red, left_key_q);
		r_d0 = color_dist(item_s1.luma_first,  item_s1.chroma_blue, item_s1.chroma_red, right_key_q);
		r_d1 = color_dist(item_s1.luma_second, item_s1.chroma_blue, item_s1.chroma_red, right_key_q);
		l_m0 = l_d0 < thr_q;
		l_m1 = l_d1 < thr_q;
		r_m0 = r_d0 < thr_q;
		r_m1 = r_d1 < thr_q;

		// Left: row - col > best_row - best_col, rearranged to stay unsigned.
		left_next = left_cur;
		l_upd     = 1'b0;
		if (l_in && l_m0) begin
			if (row_w + 11'(left_cur.col) > 11'(left_cur.row) + col0_w) begin
				l_upd         = 1'b1;
				left_next.col = col0;
				left_next.row = item_s1.pixel_row;
			end
		end else if (l_in && l_m1) begin
			if (row_w + 11'(left_cur.col) > 11'(left_cur.row) + col1_w) begin
				l_upd         = 1'b1;
				left_next.col = col1;
				left_next.row = item_s1.pixel_row;
			end
		end

		// Right: the odd pixel is tested first.
		right_next = right_cur;
		r_upd      = 1'b0;
		if (r_in && r_m1) begin
			if (row_w + col1_w > 11'(right_cur.row) + 11'(right_cur.col)) begin
				r_upd          = 1'b1;
				right_next.col = col1;
				right_next.row = item_s1.pixel_row;
			end
		end else if (r_in && r_m0) begin
			if (row_w + col0_w > 11'(right_cur.row) + 11'(right_cur.col)) begin
				r_upd          = 1'b1;
				right_next.col = col0;
				right_next.row = item_s1.pixel_row;
			end
		end
	end

	// A pair leaves the input stage unless it ends a frame and the
	// previous result is still waiting.
	assign go_s1         = valid_s1 && (!item_s1.frame_end || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go_s1;
	assign cfg_hit       = cfg_wen && (cfg_addr <= CFG_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_x_q    <= '0;
			left_y_q    <= '0;
			right_x_q   <= '0;
			right_y_q   <= '0;
			left_key_q  <= KEY_RESET;
			right_key_q <= KEY_RESET;
			thr_q       <= THR_RESET;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_LEFT_X:    left_x_q    <= cfg_wdata[COL_W-1:0];
				CFG_LEFT_Y:    left_y_q    <= cfg_wdata[ROW_W-1:0];
				CFG_RIGHT_X:   right_x_q   <= cfg_wdata[COL_W-1:0];
				CFG_RIGHT_Y:   right_y_q   <= cfg_wdata[ROW_W-1:0];
				CFG_LEFT_KEY:  left_key_q  <= cfg_wdata[KEY_W-1:0];
				CFG_RIGHT_KEY: right_key_q <= cfg_wdata[KEY_W-1:0];
				CFG_THRESHOLD: thr_q       <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			left_fresh_q  <= 1'b1;
			right_fresh_q <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (cfg_hit || (go_s1 && item_s1.frame_end)) begin
				left_fresh_q  <= 1'b1;
				right_fresh_q <= 1'b1;
			end else if (go_s1) begin
				if (l_upd) begin
					left_fresh_q <= 1'b0;
				end
				if (r_upd) begin
					right_fresh_q <= 1'b0;
				end
			end
			if (go_s1 && item_s1.frame_end) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.luma_first  <= s_axis_tdata[7:0];
			item_s1.chroma_blue <= s_axis_tdata[15:8];
			item_s1.luma_second <= s_axis_tdata[23:16];
			item_s1.chroma_red  <= s_axis_tdata[31:24];
			item_s1.pixel_row   <= s_axis_tdata[32 +: ROW_W];
			item_s1.pair_column <= s_axis_tdata[32 + ROW_W +: COL_W];
			item_s1.frame_end   <= s_axis_tlast;
		end
		if (go_s1 && l_upd) begin
			left_best_q <= left_next;
		end
		if (go_s1 && r_upd) begin
			right_best_q <= right_next;
		end
		if (go_s1 && item_s1.frame_end) begin
			out_left_q  <= left_next;
			out_right_q <= right_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_right_q.row, out_right_q.col,
		out_left_q.row, out_left_q.col});

endmodule

`default_nettype wire

// ===== tb/tb_color_key_corner_search.sv =====
`timescale 1ns / 1ps

// Testbench for the colour-key corner search.
// A queue of pixel pairs, filled by the stimulus process below, feeds a driver
// that presents one request at a time on the slave stream. A monitor at the
// rising edge passes each accepted pair to a corner tracker, which keeps its
// own copy of the registers and of the four kept positions. On a frame end it
// queues the corners that the block has to report. Each result taken from the
// master stream is compared field by field with the oldest queued report.
module tb_color_key_corner_search;
	import ckcs_pkg::*;

	localparam int FRAME_WIDTH  = 640;
	localparam int FRAME_HEIGHT = 480;
	localparam int RADIUS       = 25;

	// Register index that lies beyond the register list; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	localparam int ROW_MAX = (1 << ROW_W) - 1;
	localparam int COL_MAX = (1 << COL_W) - 1;
	localparam int THR_MAX = (1 << THR_W) - 1;

	// Clipped search window; the end bounds are exclusive.
	typedef struct {
		int sx;
		int ex;
		int sy;
		int ey;
	} window_t;

	// Result layout on the master stream, left_corner_col in the lowest bits.
	typedef struct packed {
		logic [ROW_W-1:0] right_row;
		logic [COL_W-1:0] right_col;
		logic [ROW_W-1:0] left_row;
		logic [COL_W-1:0] left_col;
	} corner_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_DAT_W-1:0]   cfg_wdata = '0;

	color_key_corner_search #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT),
		.RADIUS(RADIUS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Our copy of the registers, starting from their reset values.
	logic [COL_W-1:0] left_cx = '0;
	logic [ROW_W-1:0] left_cy = '0;
	logic [COL_W-1:0] right_cx = '0;
	logic [ROW_W-1:0] right_cy = '0;
	logic [KEY_W-1:0] left_key = 24'hFF8080;
	logic [KEY_W-1:0] right_key = 24'hFF8080;
	logic [THR_W-1:0] key_thr = 10'd15;

	// Kept corner positions of the frame in progress.
	int left_best_col;
	int left_best_row;
	int right_best_col;
	int right_best_row;

	pixel_pair_t    pairs_to_send[$];
	corner_report_t corners_due[$];

	int mismatch_count = 0;

	// Handshake pacing: percent chance of an idle burst per request or receiver draw.
	logic calm = 1'b0;
	int   gap_pct = 0;
	int   stall_pct = 0;
	int   send_gap = 0;
	int   stall_left = 0;
	logic pair_taken = 1'b0;

	pixel_pair_t    next_pair;
	pixel_pair_t    seen_pair;
	corner_report_t got_corners;
	corner_report_t want_corners;
	logic [IN_TDATA_W-1:0] bus_word;

	function automatic int clip(input int v, input int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	function automatic int gap(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Square window around a centre, clipped to the frame, start edges made even.
	function automatic window_t clip_window(input int cx, input int cy);
		window_t w;
		w.sx = (cx > RADIUS) ? cx - RADIUS : 0;
		w.ex = (cx + RADIUS < FRAME_WIDTH) ? cx + RADIUS : FRAME_WIDTH;
		w.sy = (cy > RADIUS) ? cy - RADIUS : 0;
		w.ey = (cy + RADIUS < FRAME_HEIGHT) ? cy + RADIUS : FRAME_HEIGHT;
		w.sx = w.sx - (w.sx % 2);
		w.sy = w.sy - (w.sy % 2);
		return w;
	endfunction

	function automatic bit in_window(input window_t w, input int row, input int col);
		return row >= w.sy && row < w.ey && col >= w.sx && col < w.ex;
	endfunction

	// The left search starts from the far top right of its window, the right search
	// from the top left, so that any match inside the window improves on it or ties.
	task automatic restart_corners();
		window_t lw;
		window_t rw;
		lw = clip_window(left_cx, left_cy);
		rw = clip_window(right_cx, right_cy);
		left_best_col = lw.ex - 1;
		left_best_row = lw.sy;
		right_best_col = rw.sx;
		right_best_row = rw.sy;
	endtask

	// Updates the kept corners with one accepted pair and, on a frame end, queues
	// the report the block owes.
	task automatic track_corners(input pixel_pair_t p);
		window_t lw;
		window_t rw;
		corner_report_t due;
		int row;
		int col;
		int chroma;
		int thr;
		lw = clip_window(left_cx, left_cy);
		rw = clip_window(right_cx, right_cy);
		row = p.pixel_row;
		col = p.pair_column;
		col = col - (col % 2);
		thr = key_thr;

		// The left window looks at the even pixel first; the odd one only on a miss.
		if (in_window(lw, row, col)) begin
			chroma = gap(left_key[15:8], p.chroma_blue) + gap(left_key[7:0], p.chroma_red);
			if (gap(left_key[23:16], p.luma_first) + chroma < thr) begin
				if (row - col > left_best_row - left_best_col) begin
					left_best_col = col;
					left_best_row = row;
				end
			end else if (gap(left_key[23:16], p.luma_second) + chroma < thr) begin
				if (row - col - 1 > left_best_row - left_best_col) begin
					left_best_col = col + 1;
					left_best_row = row;
				end
			end
		end

		// The right window favours the odd pixel, which lies further to the right.
		if (in_window(rw, row, col)) begin
			chroma = gap(right_key[15:8], p.chroma_blue) + gap(right_key[7:0], p.chroma_red);
			if (gap(right_key[23:16], p.luma_second) + chroma < thr) begin
				if (row + col + 1 > right_best_row + right_best_col) begin
					right_best_col = col + 1;
					right_best_row = row;
				end
			end else if (gap(right_key[23:16], p.luma_first) + chroma < thr) begin
				if (row + col > right_best_row + right_best_col) begin
					right_best_col = col;
					right_best_row = row;
				end
			end
		end

		if (p.frame_end) begin
			due.left_col = left_best_col[COL_W-1:0];
			due.left_row = left_best_row[ROW_W-1:0];
			due.right_col = right_best_col[COL_W-1:0];
			due.right_row = right_best_row[ROW_W-1:0];
			corners_due.push_back(due);
			restart_corners();
		end
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// Monitor: both streams are sampled at the rising edge. The result is checked
	// before the pair of the same edge is tracked, although a pair can never
	// produce its result in the cycle it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			pair_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				got_corners = m_axis_tdata[OUT_BITS-1:0];
				if (corners_due.size() == 0) begin
					check_field("unrequested result, left_corner_col", -1, got_corners.left_col);
				end else begin
					want_corners = corners_due.pop_front();
					check_field("left_corner_col", want_corners.left_col, got_corners.left_col);
					check_field("left_corner_row", want_corners.left_row, got_corners.left_row);
					check_field("right_corner_col", want_corners.right_col,
						got_corners.right_col);
					check_field("right_corner_row", want_corners.right_row,
						got_corners.right_row);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen_pair = {s_axis_tlast, s_axis_tdata[IN_BITS-1:0]};
				track_corners(seen_pair);
			end
		end
	end

	// Driver: a new request is offered at the falling edge once the previous one
	// has been accepted. The pair struct below its frame_end bit has exactly the
	// tdata layout, so it is copied across and the top bits stay zero.
	always @(negedge clk) begin
		if (!s_axis_tvalid || pair_taken) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pairs_to_send.size() != 0 && !calm
					&& $urandom_range(0, 99) < gap_pct) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= $urandom_range(0, 15);
			end else if (pairs_to_send.size() != 0) begin
				next_pair = pairs_to_send.pop_front();
				bus_word = '0;
				bus_word[IN_BITS-1:0] = next_pair[IN_BITS-1:0];
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= bus_word;
				s_axis_tlast <= next_pair.frame_end;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: back-pressure comes in random bursts.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Register writes happen only while the block is idle, so the copy here can be
	// updated ahead of the edge that performs the write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= CFG_DAT_W'(val);
		case (idx)
		CFG_LEFT_X:    left_cx = val[COL_W-1:0];
		CFG_LEFT_Y:    left_cy = val[ROW_W-1:0];
		CFG_RIGHT_X:   right_cx = val[COL_W-1:0];
		CFG_RIGHT_Y:   right_cy = val[ROW_W-1:0];
		CFG_LEFT_KEY:  left_key = val[KEY_W-1:0];
		CFG_RIGHT_KEY: right_key = val[KEY_W-1:0];
		CFG_THRESHOLD: key_thr = val[THR_W-1:0];
		default: ;
		endcase
		if (idx != CFG_SPARE)
			restart_corners();
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Waits until every pair has been accepted and every report has arrived, then
	// lets the pipeline drain pairs that produce no result.
	task automatic settle();
		while (pairs_to_send.size() != 0 || s_axis_tvalid || corners_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic pixel_pair_t make_pair(input int y0, input int u, input int y1,
			input int v, input int row, input int col, input logic last);
		pixel_pair_t p;
		p.luma_first = 8'(y0);
		p.chroma_blue = 8'(u);
		p.luma_second = 8'(y1);
		p.chroma_red = 8'(v);
		p.pixel_row = ROW_W'(row);
		p.pair_column = COL_W'(col);
		p.frame_end = last;
		return p;
	endfunction

	function automatic logic [7:0] near_value(input int c, input int spread);
		int n;
		n = c + $urandom_range(0, 2 * spread) - spread;
		return 8'(clip(n, 255));
	endfunction

	// Mostly pairs in or just around one of the windows, coloured close to that
	// window's key so that matches and near misses are frequent; the rest is noise
	// over the whole field range, out-of-frame positions included.
	function automatic pixel_pair_t random_pair(input logic last);
		pixel_pair_t p;
		logic [63:0] noise;
		logic [KEY_W-1:0] key;
		int cx;
		int cy;
		int spread;
		int offset;
		noise = {$urandom, $urandom};
		p = noise[$bits(pixel_pair_t)-1:0];
		if ($urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 1) == 0) begin
				cx = left_cx;
				cy = left_cy;
				key = left_key;
			end else begin
				cx = right_cx;
				cy = right_cy;
				key = right_key;
			end
			offset = $urandom_range(0, 2 * RADIUS + 3);
			p.pixel_row = ROW_W'(clip(cy + offset - RADIUS - 2, ROW_MAX));
			offset = $urandom_range(0, 2 * RADIUS + 3);
			p.pair_column = COL_W'(clip(cx + offset - RADIUS - 2, COL_MAX));
			spread = key_thr / 3 + 2;
			p.chroma_blue = near_value(key[15:8], spread);
			p.chroma_red = near_value(key[7:0], spread);
			if ($urandom_range(0, 1))
				p.luma_first = near_value(key[23:16], spread);
			if ($urandom_range(0, 1))
				p.luma_second = near_value(key[23:16], spread);
		end
		p.frame_end = last;
		return p;
	endfunction

	// Centres at the frame edges, beyond them (cut or empty windows) or anywhere inside;
	// sometimes with junk above the register width, which must be dropped.
	function automatic int pick_center(input int top, input int bits);
		int c;
		case ($urandom_range(0, 9))
		0: c = 0;
		1: c = top;
		2: c = $urandom_range(top + 1, (1 << bits) - 1);
		default: c = $urandom_range(0, top);
		endcase
		if ($urandom_range(0, 3) == 0)
			c = c | ($urandom << bits);
		return c;
	endfunction

	function automatic int pick_key();
		case ($urandom_range(0, 7))
		0: return 0;
		1: return 24'hFFFFFF;
		default: return $urandom_range(0, 24'hFFFFFF);
		endcase
	endfunction

	task automatic shuffle_config();
		if ($urandom_range(0, 1))
			write_reg(CFG_LEFT_X, pick_center(FRAME_WIDTH, COL_W));
		if ($urandom_range(0, 1))
			write_reg(CFG_LEFT_Y, pick_center(FRAME_HEIGHT, ROW_W));
		if ($urandom_range(0, 1))
			write_reg(CFG_RIGHT_X, pick_center(FRAME_WIDTH, COL_W));
		if ($urandom_range(0, 1))
			write_reg(CFG_RIGHT_Y, pick_center(FRAME_HEIGHT, ROW_W));
		if ($urandom_range(0, 1))
			write_reg(CFG_LEFT_KEY, pick_key());
		if ($urandom_range(0, 1))
			write_reg(CFG_RIGHT_KEY, pick_key());
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 7))
			0: write_reg(CFG_THRESHOLD, 0);
			1: write_reg(CFG_THRESHOLD, 766);
			2: write_reg(CFG_THRESHOLD, THR_MAX);
			default: write_reg(CFG_THRESHOLD, $urandom_range(1, 80));
			endcase
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(CFG_SPARE, $urandom);
		end_writes();
	endtask

	// Frames of one to two dozen pairs. Now and then a frame is left open, so that
	// the next restarting register write has to abandon the search in progress.
	task automatic fill_frames(input int target);
		int queued;
		int frame_len;
		queued = 0;
		while (queued < target) begin
			frame_len = $urandom_range(1, 24);
			for (int k = 0; k < frame_len; k++)
				pairs_to_send.push_back(random_pair(k == frame_len - 1));
			queued += frame_len;
		end
		if ($urandom_range(0, 9) == 0)
			pairs_to_send.push_back(random_pair(1'b0));
	endtask

	initial begin
		int idle_mix[3];
		idle_mix = '{0, 15, 50};
		restart_corners();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: both windows in the top left corner, key 0xFF8080,
		// threshold 15. Covers a match on the even pixel, a match on the odd pixel
		// only, a distance exactly at the threshold, an odd pair column, ties,
		// a row just outside the window and an out-of-frame frame end.
		gap_pct = 20;
		stall_pct = 20;
		pairs_to_send.push_back(make_pair(8'hFF, 8'h80, 8'hFF, 8'h80, 0, 0, 1'b0));
		pairs_to_send.push_back(make_pair(8'hF8, 8'h87, 8'h00, 8'h80, 2, 4, 1'b0));
		pairs_to_send.push_back(make_pair(8'hF7, 8'h87, 8'hFF, 8'h80, 10, 2, 1'b0));
		pairs_to_send.push_back(make_pair(8'hFF, 8'h80, 8'hFF, 8'h80, 20, 7, 1'b0));
		pairs_to_send.push_back(make_pair(8'hFF, 8'h80, 8'hFF, 8'h80, 22, 8, 1'b0));
		pairs_to_send.push_back(make_pair(8'hFF, 8'h80, 8'hFF, 8'h80, 24, 6, 1'b0));
		pairs_to_send.push_back(make_pair(8'hFF, 8'h80, 8'hFF, 8'h80, 25, 0, 1'b0));
		pairs_to_send.push_back(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
		pairs_to_send.push_back(make_pair(0, 8'hFF, 0, 8'hFF, ROW_MAX, COL_MAX, 1'b1));
		settle();

		// Every register once, plus the index beyond the list. Windows at the bottom
		// right edge, overlapping; extreme key colours and a threshold that every
		// pixel passes.
		write_reg(CFG_SPARE, 24'hFFFFFF);
		write_reg(CFG_LEFT_X, FRAME_WIDTH);
		write_reg(CFG_LEFT_Y, FRAME_HEIGHT);
		write_reg(CFG_RIGHT_X, 613);
		write_reg(CFG_RIGHT_Y, 457);
		write_reg(CFG_LEFT_KEY, 24'h000000);
		write_reg(CFG_RIGHT_KEY, 24'hFFFFFF);
		write_reg(CFG_THRESHOLD, 766);
		end_writes();
		pairs_to_send.push_back(make_pair(8'h40, 8'h40, 8'h40, 8'h40, 479, 638, 1'b0));
		pairs_to_send.push_back(make_pair(0, 0, 0, 0, 454, 614, 1'b0));
		pairs_to_send.push_back(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 479, 636, 1'b0));
		pairs_to_send.push_back(make_pair(8'h10, 8'hE0, 8'h70, 8'h01, 478, 635, 1'b0));
		pairs_to_send.push_back(make_pair(8'hFF, 0, 8'hFF, 0, FRAME_HEIGHT, FRAME_WIDTH, 1'b0));
		pairs_to_send.push_back(make_pair(8'h80, 8'h80, 8'h80, 8'h80, 453, 612, 1'b1));
		settle();

		// Empty windows and a zero threshold: the start positions come back.
		write_reg(CFG_LEFT_X, COL_MAX);
		write_reg(CFG_LEFT_Y, 0);
		write_reg(CFG_RIGHT_X, 0);
		write_reg(CFG_RIGHT_Y, ROW_MAX);
		write_reg(CFG_THRESHOLD, 0);
		end_writes();
		pairs_to_send.push_back(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
		pairs_to_send.push_back(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 300, 630, 1'b1));
		settle();

		// Random part: a new register setting per phase, with varied idling on both
		// sides. The last two phases run at full rate.
		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph >= 10);
			gap_pct = idle_mix[$urandom_range(0, 2)];
			stall_pct = idle_mix[$urandom_range(0, 2)];
			shuffle_config();
			fill_frames(85);
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && corners_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// The timeout ends a hung run; the slowest legal run, with every pair behind the
	// longest send gap and every result behind the longest stall, stays within it.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
